// ----- hdl/rbb_pkg.sv -----
// ----------------------------------------------------------------------------
// rbb_pkg
// Shared types and constants of the Renko brick builder.
// ----------------------------------------------------------------------------
`default_nettype none

package rbb_pkg;

  localparam int unsigned PRICE_BITS = 32;
  localparam int unsigned TIME_BITS  = 48;
  localparam int unsigned VOL_BITS   = 32;
  localparam int unsigned SIZE_BITS  = 16;
  localparam int unsigned APB_DW     = 32;
  localparam int unsigned APB_AW     = 2;

  localparam logic [APB_AW-1:0] REG_BRICK_SIZE = '0;

  localparam logic [SIZE_BITS-1:0] BRICK_SIZE_RST = SIZE_BITS'(10);
  localparam logic [VOL_BITS-1:0]  VOL_MAX        = '1;

  localparam logic DIR_LONG  = 1'b0;
  localparam logic DIR_SHORT = 1'b1;

  typedef struct packed {
    logic [PRICE_BITS-1:0] bid_price;
    logic [TIME_BITS-1:0]  tick_time;
  } rbb_tick_t;

  typedef struct packed {
    logic                  direction;
    logic [PRICE_BITS-1:0] open_px;
    logic [PRICE_BITS-1:0] close_px;
    logic [TIME_BITS-1:0]  open_ts;
    logic [TIME_BITS-1:0]  close_ts;
    logic [VOL_BITS-1:0]   tick_volume;
  } rbb_brick_t;

endpackage

`default_nettype wire

// ----- hdl/renko_brick_builder_top.sv -----
// ----------------------------------------------------------------------------
// renko_brick_builder_top
// Turns price ticks into Renko bricks of a programmable height.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                payload
//  tick      in   in_valid_i / in_stall_o  in_data_i   (rbb_tick_t)
//  brick     out  out_valid_o / out_stall_i out_data_o (rbb_brick_t)
//  config    in   APB write, reg 0 @ 0x0   brick_size  (16 bits)
//
//  One tick per cycle sustained while the output is not stalled; a brick
//  reaches the output register when its tick leaves the tick register.
//  Ticks are registered, then evaluated against the brick state in one
//  pass of compare/add logic that loads the output register.
//  A tick producing no brick still takes its slot in the evaluation stage.
//  A stalled output register holds its brick and backs up the tick register.
//  Reset clears all flags and the tick count; brick_size returns to 10.
// ----------------------------------------------------------------------------
`default_nettype none

module renko_brick_builder_top
  import rbb_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,

  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire rbb_tick_t         in_data_i,

  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output rbb_brick_t             out_data_o,

  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0]      prdata,
  output logic                   pready
);

  logic [SIZE_BITS-1:0]  brick_size_q;

  logic                  in_valid_q;
  rbb_tick_t             in_q;

  logic                  have_brick_q, have_brick_d;
  logic                  have_origin_q, have_origin_d;
  logic [VOL_BITS-1:0]   pend_q, pend_d;
  logic [PRICE_BITS-1:0] origin_price_q;
  logic [TIME_BITS-1:0]  origin_time_q;
  logic                  prev_dir_q;
  logic [PRICE_BITS-1:0] prev_open_q, prev_close_q;
  logic [TIME_BITS-1:0]  prev_open_time_q, prev_close_time_q;

  logic                  out_valid_q;
  rbb_brick_t            out_q;

  logic                  advance, step;
  logic [VOL_BITS-1:0]   pend_inc;
  logic [PRICE_BITS-1:0] bid, cont_ref, rev_ref, size_ext;
  logic [TIME_BITS-1:0]  cont_time, rev_time;
  logic                  dir_ref;
  logic                  cont_rise, cont_fall, rev_rise, rev_fall;
  logic                  cont_hit, rev_hit, emit;
  rbb_brick_t            brick;

  // APB
  assign pready = 1'b1;
  assign prdata = (paddr == REG_BRICK_SIZE) ? APB_DW'(brick_size_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brick_size_q <= BRICK_SIZE_RST;
    end else if (psel && penable && pwrite && paddr == REG_BRICK_SIZE) begin
      brick_size_q <= pwdata[SIZE_BITS-1:0];
    end
  end

  // handshake
  assign advance    = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  // evaluation
  assign bid      = in_q.bid_price;
  assign size_ext = PRICE_BITS'(brick_size_q);
  assign pend_inc = (pend_q == VOL_MAX) ? pend_q : pend_q + VOL_BITS'(1);

  assign dir_ref   = have_brick_q ? prev_dir_q : DIR_LONG;
  assign cont_ref  = have_brick_q ? prev_close_q : origin_price_q;
  assign rev_ref   = have_brick_q ? prev_open_q : origin_price_q;
  assign cont_time = have_brick_q ? prev_close_time_q : origin_time_q;
  assign rev_time  = have_brick_q ? prev_open_time_q : origin_time_q;

  assign cont_rise = (bid > cont_ref) && ((bid - cont_ref) >= size_ext);
  assign cont_fall = (bid < cont_ref) && ((cont_ref - bid) >= size_ext);
  assign rev_rise  = (bid > rev_ref) && ((bid - rev_ref) >= size_ext);
  assign rev_fall  = (bid < rev_ref) && ((rev_ref - bid) >= size_ext);

  assign cont_hit = (dir_ref == DIR_LONG) ? cont_rise : cont_fall;
  assign rev_hit  = (dir_ref == DIR_LONG) ? rev_fall : rev_rise;
  assign emit     = (have_brick_q || have_origin_q) && (cont_hit || rev_hit);

  always_comb begin
    brick.close_ts    = in_q.tick_time;
    brick.tick_volume = pend_inc;
    if (cont_hit) begin
      brick.direction = dir_ref;
      brick.open_px   = cont_ref;
      brick.open_ts   = cont_time;
    end else begin
      brick.direction = ~dir_ref;
      brick.open_px   = rev_ref;
      brick.open_ts   = rev_time;
    end
    brick.close_px = (brick.direction == DIR_SHORT) ? brick.open_px - size_ext
                                                    : brick.open_px + size_ext;
  end

  always_comb begin
    have_brick_d  = have_brick_q;
    have_origin_d = have_origin_q;
    pend_d        = pend_inc;
    if (emit) begin
      have_brick_d  = 1'b1;
      have_origin_d = 1'b0;
      pend_d        = '0;
    end else if (!have_brick_q && !have_origin_q) begin
      have_origin_d = 1'b1;
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      have_brick_q  <= 1'b0;
      have_origin_q <= 1'b0;
      pend_q        <= '0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= step && emit;
      end
      if (step) begin
        have_brick_q  <= have_brick_d;
        have_origin_q <= have_origin_d;
        pend_q        <= pend_d;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (step && !have_brick_q && !have_origin_q) begin
      origin_price_q <= bid;
      origin_time_q  <= in_q.tick_time;
    end
    if (step && emit) begin
      out_q             <= brick;
      prev_dir_q        <= brick.direction;
      prev_open_q       <= brick.open_px;
      prev_close_q      <= brick.close_px;
      prev_open_time_q  <= brick.open_ts;
      prev_close_time_q <= brick.close_ts;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks
  a_pend_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && emit |=> pend_q == '0)
    else $error("tick count not restarted after brick");

  a_brick_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    have_brick_q |=> have_brick_q)
    else $error("brick state lost");

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && out_valid_q)
    else $error("tick stalled with free pipeline");

  a_no_origin_no_brick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && !have_brick_q && !have_origin_q |=> !have_brick_q && have_origin_q)
    else $error("opening tick mishandled");

endmodule

`default_nettype wire

// ----- tb/tb_renko_brick_builder_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_renko_brick_builder_top
// Self-checking bench for the Renko brick builder.
// A driver feeds tick requests from a queue with random gaps. Each accepted
// tick runs through a brick predictor. A monitor applies random stalls and
// compares every brick against the oldest predicted one. The brick height is
// reprogrammed over APB between phases (zero, one, full range and others),
// and each write is read back.
// ----------------------------------------------------------------------------

module tb_renko_brick_builder_top
  import rbb_pkg::*;
();

  localparam longint PRICE_TOP = 64'hFFFF_FFFF;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  rbb_tick_t         in_data_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  rbb_brick_t        out_data_o;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  renko_brick_builder_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  rbb_tick_t  tick_q[$];
  rbb_brick_t brick_due_q[$];
  int unsigned err_cnt = 0;
  logic drv_idle_en = 1'b1;
  logic mon_idle_en = 1'b1;
  logic [TIME_BITS-1:0] stamp = '0;

  // brick state mirror
  logic [SIZE_BITS-1:0]  brick_height = BRICK_SIZE_RST;
  logic                  have_brick = 1'b0;
  logic                  have_origin = 1'b0;
  logic [PRICE_BITS-1:0] origin_price = '0;
  logic [TIME_BITS-1:0]  origin_time = '0;
  logic [VOL_BITS-1:0]   ticks_in_brick = '0;
  rbb_brick_t            last_brick = '0;

  function automatic logic rises_from(logic [PRICE_BITS-1:0] p, logic [PRICE_BITS-1:0] r);
    return (p > r) && ((p - r) >= PRICE_BITS'(brick_height));
  endfunction

  function automatic logic falls_from(logic [PRICE_BITS-1:0] p, logic [PRICE_BITS-1:0] r);
    return (p < r) && ((r - p) >= PRICE_BITS'(brick_height));
  endfunction

  task automatic build_brick(input rbb_tick_t tk);
    rbb_brick_t b;
    logic       hit;
    b = '0;
    hit = 1'b0;
    if (ticks_in_brick != VOL_MAX) ticks_in_brick = ticks_in_brick + 1'b1;
    if (!have_brick) begin
      if (!have_origin) begin
        have_origin = 1'b1;
        origin_price = tk.bid_price;
        origin_time = tk.tick_time;
      end else if (rises_from(tk.bid_price, origin_price)) begin
        hit = 1'b1;
        b.direction = DIR_LONG;
        b.open_px = origin_price;
        b.open_ts = origin_time;
      end else if (falls_from(tk.bid_price, origin_price)) begin
        hit = 1'b1;
        b.direction = DIR_SHORT;
        b.open_px = origin_price;
        b.open_ts = origin_time;
      end
    end else if (last_brick.direction == DIR_LONG) begin
      if (rises_from(tk.bid_price, last_brick.close_px)) begin
        hit = 1'b1;
        b.direction = DIR_LONG;
        b.open_px = last_brick.close_px;
        b.open_ts = last_brick.close_ts;
      end else if (falls_from(tk.bid_price, last_brick.open_px)) begin
        hit = 1'b1;
        b.direction = DIR_SHORT;
        b.open_px = last_brick.open_px;
        b.open_ts = last_brick.open_ts;
      end
    end else begin
      if (falls_from(tk.bid_price, last_brick.close_px)) begin
        hit = 1'b1;
        b.direction = DIR_SHORT;
        b.open_px = last_brick.close_px;
        b.open_ts = last_brick.close_ts;
      end else if (rises_from(tk.bid_price, last_brick.open_px)) begin
        hit = 1'b1;
        b.direction = DIR_LONG;
        b.open_px = last_brick.open_px;
        b.open_ts = last_brick.open_ts;
      end
    end
    if (hit) begin
      b.close_px = (b.direction == DIR_LONG) ? b.open_px + PRICE_BITS'(brick_height)
                                             : b.open_px - PRICE_BITS'(brick_height);
      b.close_ts = tk.tick_time;
      b.tick_volume = ticks_in_brick;
      last_brick = b;
      have_brick = 1'b1;
      have_origin = 1'b0;
      ticks_in_brick = '0;
      brick_due_q.insert(brick_due_q.size(), b);
    end
  endtask

  // mostly short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  // tick driver
  int unsigned gap_left = 0;
  always @(posedge clk_i) begin : drv
    rbb_tick_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) build_brick(in_data_i);
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (tick_q.size() != 0) begin
          nxt = tick_q.pop_front();
          in_data_i <= nxt;
          in_valid_i <= 1'b1;
          gap_left <= drv_idle_en ? pick_gap() : 0;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // brick monitor
  int unsigned stall_left = 0;
  always @(posedge clk_i) begin : mon
    rbb_brick_t want;
    rbb_brick_t got;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        got = out_data_o;
        if (brick_due_q.size() == 0) begin
          if (err_cnt < 10)
            $display("%0t: unexpected brick dir=%0b open=%0d close=%0d ot=%0d ct=%0d vol=%0d",
                     $realtime, got.direction, got.open_px, got.close_px,
                     got.open_ts, got.close_ts, got.tick_volume);
          err_cnt++;
        end else begin
          want = brick_due_q.pop_front();
          if (got.direction !== want.direction || got.open_px !== want.open_px ||
              got.close_px !== want.close_px || got.open_ts !== want.open_ts ||
              got.close_ts !== want.close_ts || got.tick_volume !== want.tick_volume) begin
            if (err_cnt < 10) begin
              $display("%0t: brick mismatch", $realtime);
              $display("  exp dir=%0b open=%0d close=%0d ot=%0d ct=%0d vol=%0d",
                       want.direction, want.open_px, want.close_px,
                       want.open_ts, want.close_ts, want.tick_volume);
              $display("  got dir=%0b open=%0d close=%0d ot=%0d ct=%0d vol=%0d",
                       got.direction, got.open_px, got.close_px,
                       got.open_ts, got.close_ts, got.tick_volume);
            end
            err_cnt++;
          end
        end
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
      end else if (!mon_idle_en) begin
        out_stall_i <= 1'b0;
      end else if ($urandom_range(0, 9) < 4) begin
        out_stall_i <= 1'b1;
        stall_left <= pick_gap();
      end else begin
        out_stall_i <= 1'b0;
        stall_left <= $urandom_range(0, 6);
      end
    end
  end

  task automatic queue_tick(input logic [PRICE_BITS-1:0] p, input logic [TIME_BITS-1:0] t);
    rbb_tick_t tk;
    tk.bid_price = p;
    tk.tick_time = t;
    tick_q.insert(tick_q.size(), tk);
  endtask

  task automatic apb_write(input logic [SIZE_BITS-1:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_BRICK_SIZE;
    pwdata <= APB_DW'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    brick_height = val;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== APB_DW'(val) || pready !== 1'b1) begin
      if (err_cnt < 10)
        $display("%0t: brick_size readback exp=%0d got=%0d", $realtime, val, prdata);
      err_cnt++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic drain();
    while (tick_q.size() != 0 || in_valid_i || brick_due_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // random walk with steps scaled to the brick height, with jumps and extremes
  task automatic queue_walk(input int n);
    longint p;
    longint lim;
    int unsigned r;
    lim = longint'(brick_height) * 2 + 2;
    r = $urandom_range(0, 9);
    if (r < 6) p = longint'($urandom);
    else if (r < 8) p = longint'($urandom_range(0, 200));
    else p = PRICE_TOP - longint'($urandom_range(0, 200));
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 3) p = longint'($urandom);
      else if (r == 3) p = 0;
      else if (r == 4) p = PRICE_TOP;
      else p = p + longint'($urandom_range(0, 2 * lim)) - lim;
      if (p < 0) p = 0;
      if (p > PRICE_TOP) p = PRICE_TOP;
      if ($urandom_range(0, 19) == 0) stamp = TIME_BITS'({$urandom, $urandom});
      else stamp = stamp + $urandom_range(0, 50);
      queue_tick(p[PRICE_BITS-1:0], stamp);
    end
  endtask

  initial begin : stim
    logic [SIZE_BITS-1:0] sizes[7];
    sizes = '{16'd10, 16'd1, 16'hFFFF, 16'd0, 16'd3, 16'd0, 16'd0};
    sizes[5] = SIZE_BITS'($urandom_range(2, 65534));
    sizes[6] = SIZE_BITS'($urandom_range(2, 300));
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset height: origin, first long, clipped continuation, reversals
    queue_tick(32'd100, 48'd0);
    queue_tick(32'd105, 48'd1);
    queue_tick(32'd110, 48'd2);
    queue_tick(32'd125, 48'd3);
    queue_tick(32'd115, 48'd4);
    queue_tick(32'd100, 48'd5);
    queue_tick(32'd90, 48'd6);
    queue_tick(32'd100, 48'd7);
    queue_tick(32'd110, 48'd8);
    queue_tick(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    queue_tick(32'd0, 48'd9);
    drain();

    // zero height: equal prices form nothing, strict moves form flat bricks
    apb_write(16'd0);
    queue_tick(32'd50, 48'd10);
    queue_tick(32'd50, 48'd11);
    queue_tick(32'd51, 48'd12);
    queue_tick(32'd51, 48'd13);
    queue_tick(32'd49, 48'd14);
    queue_tick(32'd0, 48'd15);
    drain();

    apb_write(16'hFFFF);
    queue_tick(32'd0, 48'd16);
    queue_tick(32'd65534, 48'd17);
    queue_tick(32'd65535, 48'd18);
    queue_tick(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    drain();

    apb_write(16'd1);
    queue_tick(32'hFFFF_FFFE, 48'd20);
    queue_tick(32'hFFFF_FFFF, 48'd21);
    queue_tick(32'd0, 48'd0);
    drain();

    stamp = TIME_BITS'({$urandom, $urandom});
    for (int ph = 0; ph < 7; ph++) begin
      apb_write(sizes[ph]);
      drv_idle_en = (ph != 2);
      mon_idle_en = (ph != 4);
      queue_walk(100);
      drain();
    end

    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
